@@ hw/rtl/kvdl_pkg.sv @@
// ----------------------------------------------------------------------------
// kvdl_pkg
// Shared types, widths and helpers for the keyframe vertex decode and lerp
// pipeline.
// ----------------------------------------------------------------------------
package kvdl_pkg;

    // number of register stages from input accept to output register
    localparam int unsigned NSTG = 6;

    // fixed-point widths
    localparam int unsigned QW    = 8;   // quantized vertex
    localparam int unsigned FW    = 16;  // Q8.8 config field
    localparam int unsigned MW    = 32;  // product of two Q8.8 values
    localparam int unsigned DW    = 41;  // decoded axis, 16 fraction bits
    localparam int unsigned DFW   = 42;  // difference of two decoded axes
    localparam int unsigned TW    = 60;  // blended value, 32 fraction bits
    localparam int unsigned POSW  = 24;  // Q16.8 output
    localparam int unsigned TEXW  = 15;  // texel coordinate
    localparam int unsigned SKW   = 13;  // skin size
    localparam int unsigned NUMW  = 29;  // texel * 16384 + size / 2
    localparam int unsigned UVW   = 16;  // Q2.14 output

    // register map of the cfg channel
    typedef enum logic [2:0]
    {
        REG_MODEL_SCALE = 3'd0,
        REG_CUR_SCALE   = 3'd1,
        REG_CUR_OFFSET  = 3'd2,
        REG_NEXT_SCALE  = 3'd3,
        REG_NEXT_OFFSET = 3'd4,
        REG_BLEND       = 3'd5,
        REG_SKIN_WIDTH  = 3'd6,
        REG_SKIN_HEIGHT = 3'd7
    } cfg_reg_t;

    // pipeline load enables, one per stage
    typedef struct packed {
        logic [NSTG-1:0] ld;
    } kvdl_ctl_t;

    // partial result of four restoring division steps
    typedef struct packed {
        logic [NUMW-1:0] rem;
        logic [3:0]      qbits;
    } tdiv_res_t;

    // four quotient bits, highest bit position hi down to hi-3
    function automatic tdiv_res_t tdiv_step4(input logic [NUMW-1:0] rem,
                                             input logic [SKW-1:0]  size,
                                             input int unsigned     hi);
        logic [NUMW-1:0] r;
        logic [NUMW-1:0] d;
        tdiv_res_t       res;
        r = rem;
        res.qbits = 4'b0000;
        for (int k = 0; k < 4; k++)
        begin
            d = {{(NUMW-SKW){1'b0}}, size} << (hi - k);
            if (r >= d)
            begin
                r = r - d;
                res.qbits[3-k] = 1'b1;
            end
        end
        res.rem = r;
        return res;
    endfunction

endpackage

@@ hw/rtl/kvdl_axis.sv @@
// ----------------------------------------------------------------------------
// kvdl_axis
// One position lane: decodes the current and next keyframe vertex of one
// file axis and blends them, rounded and saturated to Q16.8.
// ----------------------------------------------------------------------------
module kvdl_axis
(
    input  logic                                clk,
    input  kvdl_pkg::kvdl_ctl_t                 ctl,
    input  logic signed [kvdl_pkg::FW-1:0]      model_scale,
    input  logic signed [kvdl_pkg::FW-1:0]      cur_scale,
    input  logic signed [kvdl_pkg::FW-1:0]      cur_offset,
    input  logic signed [kvdl_pkg::FW-1:0]      next_scale,
    input  logic signed [kvdl_pkg::FW-1:0]      next_offset,
    input  logic        [15:0]                  blend,
    input  logic        [kvdl_pkg::QW-1:0]      cur_q,
    input  logic        [kvdl_pkg::QW-1:0]      next_q,
    output logic        [kvdl_pkg::POSW-1:0]    pos
);

    // stage 0: scale products with model scale
    logic        [kvdl_pkg::QW-1:0]   q_c_reg;
    logic        [kvdl_pkg::QW-1:0]   q_n_reg;
    logic signed [kvdl_pkg::MW-1:0]   mf_c_reg;
    logic signed [kvdl_pkg::MW-1:0]   mt_c_reg;
    logic signed [kvdl_pkg::MW-1:0]   mf_n_reg;
    logic signed [kvdl_pkg::MW-1:0]   mt_n_reg;
    logic signed [kvdl_pkg::MW-1:0]   mf_c_next;
    logic signed [kvdl_pkg::MW-1:0]   mt_c_next;
    logic signed [kvdl_pkg::MW-1:0]   mf_n_next;
    logic signed [kvdl_pkg::MW-1:0]   mt_n_next;

    // stage 1: decoded axis of both frames
    logic signed [kvdl_pkg::DW-1:0]   dc_reg;
    logic signed [kvdl_pkg::DW-1:0]   dn_reg;
    logic signed [kvdl_pkg::DW-1:0]   dc_next;
    logic signed [kvdl_pkg::DW-1:0]   dn_next;

    // stage 2: frame difference
    logic signed [kvdl_pkg::DW-1:0]   dc2_reg;
    logic signed [kvdl_pkg::DFW-1:0]  diff_reg;
    logic signed [kvdl_pkg::DFW-1:0]  diff_next;

    // stage 3: split blend products
    logic signed [kvdl_pkg::DW-1:0]   dc3_reg;
    logic        [36:0]               p_lo_reg;
    logic signed [37:0]               p_hi_reg;
    logic        [36:0]               p_lo_next;
    logic signed [37:0]               p_hi_next;

    // stage 4: blended sum
    logic        [kvdl_pkg::TW-1:0]   t_reg;
    logic        [kvdl_pkg::TW-1:0]   t_next;

    // stage 5: rounded, saturated output
    logic        [kvdl_pkg::POSW-1:0] pos_reg;
    logic        [kvdl_pkg::POSW-1:0] pos_next;
    logic        [kvdl_pkg::TW-1:0]   t_rnd;
    logic        [35:0]               r_wide;

    // datapath between stages
    always_comb
    begin
        mf_c_next = model_scale * cur_scale;
        mt_c_next = model_scale * cur_offset;
        mf_n_next = model_scale * next_scale;
        mt_n_next = model_scale * next_offset;

        dc_next = mf_c_reg * $signed({1'b0, q_c_reg}) + mt_c_reg;
        dn_next = mf_n_reg * $signed({1'b0, q_n_reg}) + mt_n_reg;

        diff_next = dn_reg - dc_reg;

        p_lo_next = diff_reg[20:0] * blend;
        p_hi_next = $signed(diff_reg[41:21]) * $signed({1'b0, blend});

        t_next = {{3{dc3_reg[kvdl_pkg::DW-1]}}, dc3_reg, 16'b0}
               + {p_hi_reg[37], p_hi_reg, 21'b0}
               + {23'b0, p_lo_reg};

        // round to 8 fraction bits, ties up, then clamp to 24 bits
        t_rnd  = t_reg + {{(kvdl_pkg::TW-24){1'b0}}, 24'h800000};
        r_wide = t_rnd[kvdl_pkg::TW-1:24];
        if ((&r_wide[35:23]) || !(|r_wide[35:23]))
        begin
            pos_next = r_wide[23:0];
        end
        else if (r_wide[35])
        begin
            pos_next = 24'h800000;
        end
        else
        begin
            pos_next = 24'h7FFFFF;
        end
    end

    // stage registers
    always_ff @(posedge clk)
    begin
        if (ctl.ld[0])
        begin
            q_c_reg  <= cur_q;
            q_n_reg  <= next_q;
            mf_c_reg <= mf_c_next;
            mt_c_reg <= mt_c_next;
            mf_n_reg <= mf_n_next;
            mt_n_reg <= mt_n_next;
        end
        if (ctl.ld[1])
        begin
            dc_reg <= dc_next;
            dn_reg <= dn_next;
        end
        if (ctl.ld[2])
        begin
            dc2_reg  <= dc_reg;
            diff_reg <= diff_next;
        end
        if (ctl.ld[3])
        begin
            dc3_reg  <= dc2_reg;
            p_lo_reg <= p_lo_next;
            p_hi_reg <= p_hi_next;
        end
        if (ctl.ld[4])
        begin
            t_reg <= t_next;
        end
        if (ctl.ld[5])
        begin
            pos_reg <= pos_next;
        end
    end

    assign pos = pos_reg;

endmodule

@@ hw/rtl/kvdl_tex_div.sv @@
// ----------------------------------------------------------------------------
// kvdl_tex_div
// Texel to Q2.14 texture coordinate: pipelined restoring divider, four
// quotient bits per stage, round to nearest and saturate.
// ----------------------------------------------------------------------------
module kvdl_tex_div
(
    input  logic                            clk,
    input  kvdl_pkg::kvdl_ctl_t             ctl,
    input  logic [kvdl_pkg::TEXW-1:0]       texel,
    input  logic [kvdl_pkg::SKW-1:0]        size,
    output logic [kvdl_pkg::UVW-1:0]        coord
);

    logic [kvdl_pkg::NUMW-1:0] num_next;
    logic                      sat_next;
    logic [kvdl_pkg::NUMW-1:0] rem_reg [5];
    logic [kvdl_pkg::UVW-1:0]  quo_reg [5];
    logic                      sat_reg [5];
    logic [kvdl_pkg::UVW-1:0]  coord_reg;

    // numerator with rounding bias, and the saturating cases up front
    always_comb
    begin
        num_next = {texel, 14'b0} + {{(kvdl_pkg::NUMW-kvdl_pkg::SKW+1){1'b0}},
                                     size[kvdl_pkg::SKW-1:1]};
        sat_next = (size == '0) || (num_next >= {size, 16'b0});
    end

    // stage 0
    always_ff @(posedge clk)
    begin
        if (ctl.ld[0])
        begin
            rem_reg[0] <= num_next;
            quo_reg[0] <= '0;
            sat_reg[0] <= sat_next;
        end
    end

    // stages 1..4: four quotient bits each, msb first
    for (genvar g = 1; g < 5; g++)
    begin : g_div
        localparam int unsigned HI = 15 - 4 * (g - 1);
        kvdl_pkg::tdiv_res_t step;

        assign step = kvdl_pkg::tdiv_step4(rem_reg[g-1], size, HI);

        always_ff @(posedge clk)
        begin
            if (ctl.ld[g])
            begin
                rem_reg[g] <= step.rem;
                quo_reg[g] <= {quo_reg[g-1][11:0], step.qbits};
                sat_reg[g] <= sat_reg[g-1];
            end
        end
    end

    // stage 5: output register
    always_ff @(posedge clk)
    begin
        if (ctl.ld[5])
        begin
            coord_reg <= sat_reg[4] ? {kvdl_pkg::UVW{1'b1}} : quo_reg[4];
        end
    end

    assign coord = coord_reg;

endmodule

@@ hw/rtl/keyframe_vertex_decode_lerp.sv @@
// ----------------------------------------------------------------------------
// keyframe_vertex_decode_lerp
// Keyframe vertex decode and linear blend with texel coordinate scaling.
// ----------------------------------------------------------------------------
// Usage
//   s_* carries one triangle corner per request: the quantized vertex of the
//   current and next keyframe and the texel pair. m_* returns the blended
//   Q16.8 position (file axes 0, 1, 2 to x, z, y) and Q2.14 texture
//   coordinates. cfg_* writes the scale, offset, blend and skin size
//   registers; cfg_ready is always high, and writes belong between runs
//   while the pipeline is empty.
//   One corner enters per cycle while m_tready does not stall the pipeline;
//   the six-stage pipeline (multiply, decode, difference, blend product, sum,
//   round) has the texture divider in parallel, retiring four quotient bits
//   per stage.
//   Reset clears all stage valid bits and loads the register defaults
//   (unit model scale, zero frames, zero blend, 256x256 skin).
//   When m_tready is low the output holds; each stage keeps accepting while
//   it has an empty slot downstream, so bubbles close up and s_tready drops
//   only once all six stages are full.
// ----------------------------------------------------------------------------
module keyframe_vertex_decode_lerp
(
    input  logic         clk,
    input  logic         rst_n,
    // cur_vx, cur_vy, cur_vz, next_vx, next_vy, next_vz, tex_s, tex_t, pad
    input  logic [79:0]  s_tdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    // pos_x, pos_y, pos_z, tex_u, tex_v
    output logic [103:0] m_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [47:0]  cfg_data
);

    logic [47:0]                   model_scale_reg;
    logic [47:0]                   cur_scale_reg;
    logic [47:0]                   cur_offset_reg;
    logic [47:0]                   next_scale_reg;
    logic [47:0]                   next_offset_reg;
    logic [15:0]                   blend_reg;
    logic [kvdl_pkg::SKW-1:0]      skin_w_reg;
    logic [kvdl_pkg::SKW-1:0]      skin_h_reg;

    logic [kvdl_pkg::NSTG-1:0]     vld_reg;
    logic [kvdl_pkg::NSTG-1:0]     vld_next;
    logic [kvdl_pkg::NSTG-1:0]     rdy;
    kvdl_pkg::kvdl_ctl_t           ctl;

    logic [kvdl_pkg::POSW-1:0]     pos_x;
    logic [kvdl_pkg::POSW-1:0]     pos_y;
    logic [kvdl_pkg::POSW-1:0]     pos_z;
    logic [kvdl_pkg::UVW-1:0]      tex_u;
    logic [kvdl_pkg::UVW-1:0]      tex_v;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            model_scale_reg <= 48'h0100_0100_0100;
            cur_scale_reg   <= '0;
            cur_offset_reg  <= '0;
            next_scale_reg  <= '0;
            next_offset_reg <= '0;
            blend_reg       <= '0;
            skin_w_reg      <= 13'd256;
            skin_h_reg      <= 13'd256;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                kvdl_pkg::REG_MODEL_SCALE:  model_scale_reg <= cfg_data;
                kvdl_pkg::REG_CUR_SCALE:    cur_scale_reg   <= cfg_data;
                kvdl_pkg::REG_CUR_OFFSET:   cur_offset_reg  <= cfg_data;
                kvdl_pkg::REG_NEXT_SCALE:   next_scale_reg  <= cfg_data;
                kvdl_pkg::REG_NEXT_OFFSET:  next_offset_reg <= cfg_data;
                kvdl_pkg::REG_BLEND:        blend_reg       <= cfg_data[15:0];
                kvdl_pkg::REG_SKIN_WIDTH:   skin_w_reg <= cfg_data[kvdl_pkg::SKW-1:0];
                kvdl_pkg::REG_SKIN_HEIGHT:  skin_h_reg <= cfg_data[kvdl_pkg::SKW-1:0];
                default:                    ;
            endcase
        end
    end

    // stage handshake: a stage takes a new item when it is empty or moves on
    always_comb
    begin
        rdy[kvdl_pkg::NSTG-1] = !vld_reg[kvdl_pkg::NSTG-1] || m_tready;
        for (int k = kvdl_pkg::NSTG - 2; k >= 0; k--)
        begin
            rdy[k] = !vld_reg[k] || rdy[k+1];
        end
        ctl.ld[0]   = rdy[0] && s_tvalid;
        vld_next[0] = rdy[0] ? s_tvalid : vld_reg[0];
        for (int k = 1; k < kvdl_pkg::NSTG; k++)
        begin
            ctl.ld[k]   = rdy[k] && vld_reg[k-1];
            vld_next[k] = rdy[k] ? vld_reg[k-1] : vld_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign s_tready = rdy[0];
    assign m_tvalid = vld_reg[kvdl_pkg::NSTG-1];

    // x from file axis 0
    kvdl_axis u_axis_x
    (
        .clk         (clk),
        .ctl         (ctl),
        .model_scale ($signed(model_scale_reg[15:0])),
        .cur_scale   ($signed(cur_scale_reg[15:0])),
        .cur_offset  ($signed(cur_offset_reg[15:0])),
        .next_scale  ($signed(next_scale_reg[15:0])),
        .next_offset ($signed(next_offset_reg[15:0])),
        .blend       (blend_reg),
        .cur_q       (s_tdata[7:0]),
        .next_q      (s_tdata[31:24]),
        .pos         (pos_x)
    );

    // y from file axis 2
    kvdl_axis u_axis_y
    (
        .clk         (clk),
        .ctl         (ctl),
        .model_scale ($signed(model_scale_reg[31:16])),
        .cur_scale   ($signed(cur_scale_reg[47:32])),
        .cur_offset  ($signed(cur_offset_reg[47:32])),
        .next_scale  ($signed(next_scale_reg[47:32])),
        .next_offset ($signed(next_offset_reg[47:32])),
        .blend       (blend_reg),
        .cur_q       (s_tdata[23:16]),
        .next_q      (s_tdata[47:40]),
        .pos         (pos_y)
    );

    // z from file axis 1
    kvdl_axis u_axis_z
    (
        .clk         (clk),
        .ctl         (ctl),
        .model_scale ($signed(model_scale_reg[47:32])),
        .cur_scale   ($signed(cur_scale_reg[31:16])),
        .cur_offset  ($signed(cur_offset_reg[31:16])),
        .next_scale  ($signed(next_scale_reg[31:16])),
        .next_offset ($signed(next_offset_reg[31:16])),
        .blend       (blend_reg),
        .cur_q       (s_tdata[15:8]),
        .next_q      (s_tdata[39:32]),
        .pos         (pos_z)
    );

    // texture coordinates
    kvdl_tex_div u_tex_u
    (
        .clk   (clk),
        .ctl   (ctl),
        .texel (s_tdata[62:48]),
        .size  (skin_w_reg),
        .coord (tex_u)
    );

    kvdl_tex_div u_tex_v
    (
        .clk   (clk),
        .ctl   (ctl),
        .texel (s_tdata[77:63]),
        .size  (skin_h_reg),
        .coord (tex_v)
    );

    assign m_tdata = {tex_v, tex_u, pos_z, pos_y, pos_x};

endmodule

@@ hw/rtl/kvdl_checker.sv @@
// ----------------------------------------------------------------------------
// kvdl_checker
// Port-level checks of the decode and lerp pipeline: reset, flow control and
// the bound on items in flight.
// ----------------------------------------------------------------------------
module kvdl_checker
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [103:0] m_tdata,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic         cfg_ready
);

    logic [2:0] cnt_reg;
    logic [2:0] cnt_next;

    // requests accepted but not yet delivered
    always_comb
    begin
        cnt_next = cnt_reg;
        if ((s_tvalid && s_tready) && !(m_tvalid && m_tready))
        begin
            cnt_next = cnt_reg + 3'd1;
        end
        else if (!(s_tvalid && s_tready) && (m_tvalid && m_tready))
        begin
            cnt_next = cnt_reg - 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    // no result shown while in reset
    a_reset_quiet: assert property (@(posedge clk) !rst_n |-> !m_tvalid)
        else $error("m_tvalid high during reset");

    // results only for outstanding requests, never more than the stages hold
    a_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg <= 3'(kvdl_pkg::NSTG)) && (!m_tvalid || cnt_reg != 3'd0))
        else $error("items in flight out of range");

    // an empty output stage frees the whole pipeline
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output stage");

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed");

    // configuration is always taken
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
        else $error("cfg_ready low");

endmodule

bind keyframe_vertex_decode_lerp kvdl_checker u_kvdl_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tdata   (m_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .cfg_ready (cfg_ready)
);

@@ bench/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Checks the keyframe vertex decode and lerp block against a cycle-free
// predictor: corners are streamed in bursts under several register settings,
// every returned vertex is compared field by field with its expectation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

    // one triangle corner, first field in the lowest bits
    typedef struct packed
    {
        logic [kvdl_pkg::TEXW-1:0] tex_t;
        logic [kvdl_pkg::TEXW-1:0] tex_s;
        logic [kvdl_pkg::QW-1:0]   next_vz;
        logic [kvdl_pkg::QW-1:0]   next_vy;
        logic [kvdl_pkg::QW-1:0]   next_vx;
        logic [kvdl_pkg::QW-1:0]   cur_vz;
        logic [kvdl_pkg::QW-1:0]   cur_vy;
        logic [kvdl_pkg::QW-1:0]   cur_vx;
    } corner_t;

    // one blended vertex, first field in the lowest bits
    typedef struct packed
    {
        logic [kvdl_pkg::UVW-1:0]  tex_v;
        logic [kvdl_pkg::UVW-1:0]  tex_u;
        logic [kvdl_pkg::POSW-1:0] pos_z;
        logic [kvdl_pkg::POSW-1:0] pos_y;
        logic [kvdl_pkg::POSW-1:0] pos_x;
    } vertex_t;

    // ------------------------------------------------------------------------
    // vertex predictor and expected vertex store
    // ------------------------------------------------------------------------
    class vertex_checker;
        logic [47:0] model_scale;
        logic [47:0] cur_scale;
        logic [47:0] cur_offset;
        logic [47:0] next_scale;
        logic [47:0] next_offset;
        logic [15:0] blend_frac;
        logic [12:0] skin_w;
        logic [12:0] skin_h;
        vertex_t     expected_vertices[$];
        int          errors;

        function new();
            model_scale = {16'h0100, 16'h0100, 16'h0100};
            cur_scale   = '0;
            cur_offset  = '0;
            next_scale  = '0;
            next_offset = '0;
            blend_frac  = '0;
            skin_w      = 13'd256;
            skin_h      = 13'd256;
            errors      = 0;
        endfunction

        function void write_reg(kvdl_pkg::cfg_reg_t idx, logic [47:0] data);
            case (idx)
                kvdl_pkg::REG_MODEL_SCALE: model_scale = data;
                kvdl_pkg::REG_CUR_SCALE:   cur_scale   = data;
                kvdl_pkg::REG_CUR_OFFSET:  cur_offset  = data;
                kvdl_pkg::REG_NEXT_SCALE:  next_scale  = data;
                kvdl_pkg::REG_NEXT_OFFSET: next_offset = data;
                kvdl_pkg::REG_BLEND:       blend_frac  = data[15:0];
                kvdl_pkg::REG_SKIN_WIDTH:  skin_w      = data[12:0];
                kvdl_pkg::REG_SKIN_HEIGHT: skin_h      = data[12:0];
                default:                   ;
            endcase
        endfunction

        // signed Q8.8 field k of a packed triple
        function longint q88(logic [47:0] word, int k);
            logic signed [15:0] f;
            f = word[16*k +: 16];
            return f;
        endfunction

        // decode both frames of one file axis and blend, round half up, saturate
        function logic [kvdl_pkg::POSW-1:0] blend_axis(int file_axis, int scale_field,
                                                       logic [kvdl_pkg::QW-1:0] cq,
                                                       logic [kvdl_pkg::QW-1:0] nq);
            longint m;
            longint c;
            longint n;
            longint t;
            longint r;
            m = q88(model_scale, scale_field);
            c = (q88(cur_scale, file_axis) * longint'(cq)
                 + q88(cur_offset, file_axis)) * m;
            n = (q88(next_scale, file_axis) * longint'(nq)
                 + q88(next_offset, file_axis)) * m;
            t = c * 65536 + (n - c) * longint'(blend_frac);
            r = (t + 8388608) >>> 24;
            if (r > 8388607)
                r = 8388607;
            if (r < -8388608)
                r = -8388608;
            return r[kvdl_pkg::POSW-1:0];
        endfunction

        // texel over skin size in Q2.14, round half up, zero size saturates
        function logic [kvdl_pkg::UVW-1:0] tex_scale(logic [kvdl_pkg::TEXW-1:0] texel,
                                                     logic [12:0] size);
            longint q;
            if (size == 0)
                return 16'hFFFF;
            q = (longint'(texel) * 16384 + longint'(size) / 2) / longint'(size);
            return (q > 65535) ? 16'hFFFF : q[kvdl_pkg::UVW-1:0];
        endfunction

        // file axis 0 -> x, axis 2 -> y, axis 1 -> z
        function void note_corner(corner_t c);
            vertex_t v;
            v.pos_x = blend_axis(0, 0, c.cur_vx, c.next_vx);
            v.pos_y = blend_axis(2, 1, c.cur_vz, c.next_vz);
            v.pos_z = blend_axis(1, 2, c.cur_vy, c.next_vy);
            v.tex_u = tex_scale(c.tex_s, skin_w);
            v.tex_v = tex_scale(c.tex_t, skin_h);
            expected_vertices.insert(expected_vertices.size(), v);
        endfunction

        function void check_result(logic [103:0] data);
            vertex_t got;
            vertex_t exp_v;
            got = data;
            if (expected_vertices.size() == 0)
            begin
                $error("vertex returned with no request outstanding");
                errors++;
                return;
            end
            exp_v = expected_vertices.pop_front();
            if (got.pos_x !== exp_v.pos_x)
            begin
                $error("pos_x mismatch: expected %0d, actual %0d",
                       $signed(exp_v.pos_x), $signed(got.pos_x));
                errors++;
            end
            if (got.pos_y !== exp_v.pos_y)
            begin
                $error("pos_y mismatch: expected %0d, actual %0d",
                       $signed(exp_v.pos_y), $signed(got.pos_y));
                errors++;
            end
            if (got.pos_z !== exp_v.pos_z)
            begin
                $error("pos_z mismatch: expected %0d, actual %0d",
                       $signed(exp_v.pos_z), $signed(got.pos_z));
                errors++;
            end
            if (got.tex_u !== exp_v.tex_u)
            begin
                $error("tex_u mismatch: expected %0d, actual %0d", exp_v.tex_u, got.tex_u);
                errors++;
            end
            if (got.tex_v !== exp_v.tex_v)
            begin
                $error("tex_v mismatch: expected %0d, actual %0d", exp_v.tex_v, got.tex_v);
                errors++;
            end
        endfunction

        function int pending();
            return expected_vertices.size();
        endfunction
    endclass

    logic         clk;
    logic         rst_n;
    logic [79:0]  s_tdata;
    logic         s_tvalid;
    logic         s_tready;
    logic [103:0] m_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [2:0]   cfg_index;
    logic [47:0]  cfg_data;

    vertex_checker chk;
    logic [9:0]    ready_phase;

    keyframe_vertex_decode_lerp u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 10 ns clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // receiver stall pattern: free running, light, heavy, long periodic stalls
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_tready    <= 1'b0;
            ready_phase <= '0;
        end
        else
        begin
            ready_phase <= ready_phase + 10'd1;
            case (ready_phase[9:8])
                2'd0: m_tready <= 1'b1;
                2'd1: m_tready <= ($urandom_range(0, 3) != 0);
                2'd2: m_tready <= ($urandom_range(0, 1) != 0);
                default: m_tready <= (ready_phase[3:0] < 4'd5);
            endcase
        end
    end

    // compare every accepted vertex
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            chk.check_result(m_tdata);
    end

    // one corner request, valid left high for a following request
    task automatic send_corner(input corner_t c);
        s_tdata  <= {2'b00, c};
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        chk.note_corner(c);
    endtask

    task automatic sender_gap(input int cycles);
        if (cycles > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    // hold off until every expected vertex has come back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (chk.pending() != 0)
            @(posedge clk);
    endtask

    task automatic write_cfg(input kvdl_pkg::cfg_reg_t idx, input logic [47:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        chk.write_reg(idx, data);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic corner_t make_corner(logic [7:0] cx, logic [7:0] cy, logic [7:0] cz,
                                            logic [7:0] nx, logic [7:0] ny, logic [7:0] nz,
                                            logic [14:0] ts, logic [14:0] tt);
        corner_t c;
        c.cur_vx  = cx;
        c.cur_vy  = cy;
        c.cur_vz  = cz;
        c.next_vx = nx;
        c.next_vy = ny;
        c.next_vz = nz;
        c.tex_s   = ts;
        c.tex_t   = tt;
        return c;
    endfunction

    function automatic logic [7:0] rand_vertex();
        case ($urandom_range(0, 7))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [14:0] rand_texel();
        case ($urandom_range(0, 5))
            0:       return 15'($urandom_range(0, 300));
            1:       return 15'h7FFF;
            default: return 15'($urandom);
        endcase
    endfunction

    function automatic corner_t rand_corner();
        return make_corner(rand_vertex(), rand_vertex(), rand_vertex(),
                           rand_vertex(), rand_vertex(), rand_vertex(),
                           rand_texel(), rand_texel());
    endfunction

    // mostly small Q8.8 values so positions stay in range, some wide or extreme
    function automatic logic [47:0] rand_triple();
        logic [47:0] w;
        logic [15:0] f;
        for (int k = 0; k < 3; k++)
        begin
            case ($urandom_range(0, 5))
                0: f = 16'($urandom);
                1:
                begin
                    case ($urandom_range(0, 3))
                        0:       f = 16'h7FFF;
                        1:       f = 16'h8000;
                        2:       f = 16'h0000;
                        default: f = 16'h0100;
                    endcase
                end
                default: f = 16'($urandom_range(0, 1536)) - 16'h0300;
            endcase
            w[16*k +: 16] = f;
        end
        return w;
    endfunction

    function automatic logic [47:0] rand_blend_word();
        logic [47:0] w;
        w = {16'($urandom), 32'($urandom)};
        case ($urandom_range(0, 5))
            0:       w[15:0] = 16'h0000;
            1:       w[15:0] = 16'hFFFF;
            default: ;
        endcase
        return w;
    endfunction

    // upper bits stay random, the block keeps only 13
    function automatic logic [47:0] rand_skin_word();
        logic [47:0] w;
        w = {16'($urandom), 32'($urandom)};
        case ($urandom_range(0, 9))
            0:       w[12:0] = 13'd0;
            1:       w[12:0] = 13'd1;
            2:       w[12:0] = 13'd4096;
            3:       ;
            default: w[12:0] = 13'($urandom_range(1, 4096));
        endcase
        return w;
    endfunction

    task automatic program_random();
        write_cfg(kvdl_pkg::REG_MODEL_SCALE, rand_triple());
        write_cfg(kvdl_pkg::REG_CUR_SCALE, rand_triple());
        write_cfg(kvdl_pkg::REG_CUR_OFFSET, rand_triple());
        write_cfg(kvdl_pkg::REG_NEXT_SCALE, rand_triple());
        write_cfg(kvdl_pkg::REG_NEXT_OFFSET, rand_triple());
        write_cfg(kvdl_pkg::REG_BLEND, rand_blend_word());
        write_cfg(kvdl_pkg::REG_SKIN_WIDTH, rand_skin_word());
        write_cfg(kvdl_pkg::REG_SKIN_HEIGHT, rand_skin_word());
    endtask

    // bursts of corners with random gaps, some stretches without gaps
    task automatic send_random(input int count);
        int sent;
        int burst;
        sent = 0;
        while (sent < count)
        begin
            burst = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 12);
            for (int j = 0; j < burst && sent < count; j++)
            begin
                send_corner(rand_corner());
                sent++;
            end
            sender_gap(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6));
        end
    endtask

    // run limit
    initial
    begin
        #3000000;
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        chk       = new();
        rst_n     = 1'b0;
        s_tdata   = '0;
        s_tvalid  = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = kvdl_pkg::REG_MODEL_SCALE;
        cfg_data  = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: zero frames, 256x256 skin
        send_corner(make_corner(0, 0, 0, 0, 0, 0, 0, 0));
        send_corner(make_corner(255, 255, 255, 255, 255, 255, 15'h7FFF, 15'h7FFF));
        send_corner(make_corner(17, 200, 90, 3, 128, 250, 15'd1000, 15'd128));

        // static case with unit model scale, narrowest skin width, 4096 skin height
        wait_drained();
        write_cfg(kvdl_pkg::REG_MODEL_SCALE, {16'h0100, 16'h0100, 16'h0100});
        write_cfg(kvdl_pkg::REG_CUR_SCALE, {16'h0080, 16'hFF00, 16'h0100});
        write_cfg(kvdl_pkg::REG_CUR_OFFSET, {16'h0000, 16'h7FFF, 16'h8000});
        write_cfg(kvdl_pkg::REG_NEXT_SCALE, {16'h0100, 16'h8000, 16'h7FFF});
        write_cfg(kvdl_pkg::REG_NEXT_OFFSET, {16'h0123, 16'hFE80, 16'h0040});
        write_cfg(kvdl_pkg::REG_BLEND, 48'h0);
        write_cfg(kvdl_pkg::REG_SKIN_WIDTH, 48'd1);
        write_cfg(kvdl_pkg::REG_SKIN_HEIGHT, 48'd4096);
        send_corner(make_corner(0, 0, 0, 0, 0, 0, 0, 0));
        send_corner(make_corner(255, 255, 255, 255, 255, 255, 15'h7FFF, 15'h7FFF));
        send_corner(make_corner(255, 255, 255, 0, 0, 0, 15'd1, 15'd2048));
        send_corner(make_corner(0, 0, 0, 255, 255, 255, 15'd0, 15'd2));
        send_corner(make_corner(128, 1, 127, 64, 254, 33, 15'h5555, 15'h2AAA));

        // full blend, extreme scales and offsets, zero width, widest 13-bit height
        wait_drained();
        write_cfg(kvdl_pkg::REG_MODEL_SCALE, {16'hFFFF, 16'h8000, 16'h7FFF});
        write_cfg(kvdl_pkg::REG_CUR_SCALE, {16'h7FFF, 16'h8000, 16'h7FFF});
        write_cfg(kvdl_pkg::REG_CUR_OFFSET, {16'h8000, 16'h7FFF, 16'h7FFF});
        write_cfg(kvdl_pkg::REG_NEXT_SCALE, {16'h8000, 16'h7FFF, 16'h8000});
        write_cfg(kvdl_pkg::REG_NEXT_OFFSET, {16'h7FFF, 16'h8000, 16'h8000});
        write_cfg(kvdl_pkg::REG_BLEND, 48'h0000_0000_FFFF);
        write_cfg(kvdl_pkg::REG_SKIN_WIDTH, 48'h0);
        write_cfg(kvdl_pkg::REG_SKIN_HEIGHT, 48'hFFFF_FFFF_FFFF);
        send_corner(make_corner(0, 0, 0, 0, 0, 0, 0, 0));
        send_corner(make_corner(255, 255, 255, 255, 255, 255, 15'h7FFF, 15'h7FFF));
        send_corner(make_corner(255, 0, 255, 0, 255, 0, 15'd4095, 15'd4096));
        send_corner(make_corner(1, 2, 3, 4, 5, 6, 15'd8191, 15'd8190));

        // half blend, odd skin sizes for rounding ties
        wait_drained();
        write_cfg(kvdl_pkg::REG_MODEL_SCALE, {16'h0180, 16'hFF80, 16'h0040});
        write_cfg(kvdl_pkg::REG_CUR_SCALE, {16'h0001, 16'hFFFF, 16'h0003});
        write_cfg(kvdl_pkg::REG_CUR_OFFSET, {16'hFFFF, 16'h0001, 16'h0000});
        write_cfg(kvdl_pkg::REG_NEXT_SCALE, {16'h0002, 16'h0005, 16'hFFFD});
        write_cfg(kvdl_pkg::REG_NEXT_OFFSET, {16'h0001, 16'hFF00, 16'h0080});
        write_cfg(kvdl_pkg::REG_BLEND, 48'h8000);
        write_cfg(kvdl_pkg::REG_SKIN_WIDTH, 48'd3);
        write_cfg(kvdl_pkg::REG_SKIN_HEIGHT, 48'd4095);
        send_corner(make_corner(0, 0, 0, 255, 255, 255, 15'd1, 15'd1));
        send_corner(make_corner(255, 255, 255, 0, 0, 0, 15'd2, 15'd4095));
        send_corner(make_corner(3, 77, 200, 9, 180, 11, 15'd11, 15'd12287));
        send_corner(make_corner(100, 100, 100, 101, 99, 100, 15'd12, 15'd30000));

        // random settings, each phase starts from an empty pipeline
        for (int ph = 0; ph < 8; ph++)
        begin
            wait_drained();
            program_random();
            send_random(75);
        end

        wait_drained();
        repeat (kvdl_pkg::NSTG + 4) @(posedge clk);
        if (chk.pending() != 0)
        begin
            $error("%0d expected vertices never returned", chk.pending());
            chk.errors++;
        end
        if (chk.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
